FILE: src/tiny_8bit_cpu_step_macros.svh
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step_macros.svh
// Assertion macros used by the RTL of the tiny 8-bit processor step block.
// ----------------------------------------------------------------------------
`ifndef TINY_8BIT_CPU_STEP_MACROS_SVH
`define TINY_8BIT_CPU_STEP_MACROS_SVH

// check cons in the same cycle as ante
`define TBCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define TBCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tbcs_pkg.sv
// ----------------------------------------------------------------------------
// tbcs_pkg
// Types and constants of the tiny 8-bit processor step block.
// ----------------------------------------------------------------------------
package tbcs_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned AddrW    = 8;
  localparam int unsigned MemDepth = 256;
  localparam int unsigned NumRegs  = 4;

  localparam logic [3:0] OPC_NOP   = 4'h0;
  localparam logic [3:0] OPC_SUB   = 4'h1;
  localparam logic [3:0] OPC_LOAD  = 4'h2;
  localparam logic [3:0] OPC_STORE = 4'h3;
  localparam logic [3:0] OPC_SKIP  = 4'h4;
  localparam logic [3:0] OPC_JALR  = 4'h5;
  localparam logic [3:0] OPC_NAND  = 4'h6;
  localparam logic [3:0] OPC_ADD   = 4'h7;
  localparam logic [3:0] OPC_GROUP = 4'h8;
  localparam logic [3:0] OPC_SLI   = 4'hC;

  localparam logic [1:0] GRP_INC = 2'd0;
  localparam logic [1:0] GRP_DEC = 2'd1;
  localparam logic [1:0] GRP_OUT = 2'd2;
  localparam logic [1:0] GRP_IN  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_WRAP    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic       ACT_LOAD    = 1'b0;
  localparam logic [7:0] RESULT_ADDR = 8'hFF;
  localparam logic [7:0] HI_MASK     = 8'hF0;
  localparam logic [7:0] LO_MASK     = 8'h0F;

  typedef logic [NumRegs-1:0][DataW-1:0] regs_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic             unknown;
    logic             is_load;
    logic             reg_we;
    logic [1:0]       reg_idx;
    logic [DataW-1:0] reg_val;
    mem_wr_t          mem_wr;
    logic [AddrW-1:0] pc_next;
    logic [AddrW-1:0] ld_addr;
    logic             out_valid;
    logic [DataW-1:0] out_char;
  } exec_t;

endpackage

FILE: src/tbcs_ram.sv
// ----------------------------------------------------------------------------
// tbcs_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tbcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

FILE: src/tbcs_mem.sv
// ----------------------------------------------------------------------------
// tbcs_mem
// Main memory: RAM plus per-byte valid bits (unwritten bytes read as zero)
// and write bypass on both registered read ports.
// ----------------------------------------------------------------------------
module tbcs_mem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tbcs_pkg::mem_wr_t             wr_i,
  input  logic [tbcs_pkg::AddrW-1:0]    fetch_addr_i,
  output logic [tbcs_pkg::DataW-1:0]    fetch_data_o,
  input  logic [tbcs_pkg::AddrW-1:0]    rd_addr_i,
  output logic [tbcs_pkg::DataW-1:0]    rd_data_o
);

  logic [tbcs_pkg::MemDepth-1:0] valid_q;
  logic [tbcs_pkg::DataW-1:0]    ram_a, ram_b;
  logic                          fvld_q, fbyp_q, rvld_q, rbyp_q;
  logic [tbcs_pkg::DataW-1:0]    byp_data_q;

  tbcs_ram #(
    .Width(tbcs_pkg::DataW),
    .Depth(tbcs_pkg::MemDepth)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (wr_i.we),
    .waddr_i  (wr_i.addr),
    .wdata_i  (wr_i.data),
    .raddr_a_i(fetch_addr_i),
    .rdata_a_o(ram_a),
    .raddr_b_i(rd_addr_i),
    .rdata_b_o(ram_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fvld_q  <= 1'b0;
      fbyp_q  <= 1'b0;
      rvld_q  <= 1'b0;
      rbyp_q  <= 1'b0;
    end else begin
      if (wr_i.we) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      fvld_q <= valid_q[fetch_addr_i];
      fbyp_q <= wr_i.we && (wr_i.addr == fetch_addr_i);
      rvld_q <= valid_q[rd_addr_i];
      rbyp_q <= wr_i.we && (wr_i.addr == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wr_i.data;
  end

  assign fetch_data_o = fbyp_q ? byp_data_q : (fvld_q ? ram_a : '0);
  assign rd_data_o    = rbyp_q ? byp_data_q : (rvld_q ? ram_b : '0);

endmodule

FILE: src/tbcs_exec.sv
// ----------------------------------------------------------------------------
// tbcs_exec
// Instruction decode and execute: register, memory and pc updates.
// ----------------------------------------------------------------------------
module tbcs_exec (
  input  logic [tbcs_pkg::DataW-1:0] ins_i,
  input  logic [tbcs_pkg::AddrW-1:0] pc_i,
  input  tbcs_pkg::regs_t            regs_i,
  input  logic [tbcs_pkg::DataW-1:0] in_char_i,
  output tbcs_pkg::exec_t            ex_o
);

  logic [3:0]                 opc;
  logic [1:0]                 rd, rs;
  logic [tbcs_pkg::DataW-1:0] vd, vs;
  logic [tbcs_pkg::AddrW-1:0] pc_inc;
  logic                       skip;

  assign opc    = ins_i[7:4];
  assign rd     = ins_i[3:2];
  assign rs     = ins_i[1:0];
  assign vd     = regs_i[rd];
  assign vs     = regs_i[rs];
  assign pc_inc = pc_i + 8'd1;
  assign skip   = ins_i[0] ? (vd != '0) : (vd == '0);

  always_comb begin
    ex_o             = '0;
    ex_o.reg_idx     = rd;
    ex_o.pc_next     = pc_inc;
    ex_o.ld_addr     = vs;
    ex_o.mem_wr.addr = vs;
    ex_o.mem_wr.data = vd;
    case (opc)
      tbcs_pkg::OPC_NOP: begin
      end
      tbcs_pkg::OPC_SUB: begin
        ex_o.reg_we  = 1'b1;
        ex_o.reg_val = vd - vs;
      end
      tbcs_pkg::OPC_LOAD: begin
        ex_o.is_load = 1'b1;
      end
      tbcs_pkg::OPC_STORE: begin
        ex_o.mem_wr.we = 1'b1;
      end
      tbcs_pkg::OPC_SKIP: begin
        ex_o.pc_next = skip ? pc_i + 8'd2 : pc_inc;
      end
      tbcs_pkg::OPC_JALR: begin
        ex_o.reg_we  = 1'b1;
        ex_o.reg_val = pc_inc;
        ex_o.pc_next = vs;
      end
      tbcs_pkg::OPC_NAND: begin
        ex_o.reg_we  = 1'b1;
        ex_o.reg_val = ~(vd & vs);
      end
      tbcs_pkg::OPC_ADD: begin
        ex_o.reg_we  = 1'b1;
        ex_o.reg_val = vd + vs;
      end
      tbcs_pkg::OPC_GROUP: begin
        case (rs)
          tbcs_pkg::GRP_INC: begin
            ex_o.reg_we  = 1'b1;
            ex_o.reg_val = vd + 8'd1;
          end
          tbcs_pkg::GRP_DEC: begin
            ex_o.reg_we  = 1'b1;
            ex_o.reg_val = vd - 8'd1;
          end
          tbcs_pkg::GRP_OUT: begin
            ex_o.out_valid = 1'b1;
            ex_o.out_char  = vd;
          end
          default: begin
            ex_o.reg_we  = 1'b1;
            ex_o.reg_val = in_char_i;
          end
        endcase
      end
      tbcs_pkg::OPC_SLI: begin
        ex_o.reg_we  = 1'b1;
        ex_o.reg_val = (vd & tbcs_pkg::HI_MASK) | (ins_i & tbcs_pkg::LO_MASK);
      end
      default: begin
        ex_o.unknown = 1'b1;
        ex_o.pc_next = pc_i;
      end
    endcase
  end

endmodule

FILE: src/tiny_8bit_cpu_step.sv
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step
// Tiny 8-bit processor: program byte writes and single instruction steps.
//
//   channel  handshake                  payload
//   in       in_valid_i / in_ready_o    action, load_addr, load_data, in_char
//   res      res_valid_o / res_ready_i  out_valid, out_char, pc_now,
//                                       result_byte, status
//
// One beat per cycle while the result slot is free, for program writes and all
// instructions but load, whose data comes from a second registered read of the
// memory after the instruction fetch port has delivered the opcode.
// The next instruction is prefetched every cycle at the next pc.
// Reset clears pc, registers and stop flag; memory reads zero until written.
// A stalled result holds in the output register; input stalls while that
// register is full and not being taken, and while a load waits in S_LDW.
// ----------------------------------------------------------------------------
`include "tiny_8bit_cpu_step_macros.svh"

module tiny_8bit_cpu_step (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       action_i,
  input  logic [7:0] load_addr_i,
  input  logic [7:0] load_data_i,
  input  logic [7:0] in_char_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic [7:0] pc_now_o,
  output logic [7:0] result_byte_o,
  output logic [1:0] status_o
);

  typedef enum logic {
    S_RUN,
    S_LDW
  } state_e;

  state_e                     state_q, state_d;
  logic [tbcs_pkg::AddrW-1:0] pc_q, pc_d;
  tbcs_pkg::regs_t            regs_q, regs_d;
  logic                       stopped_q, stopped_d;
  logic [tbcs_pkg::DataW-1:0] mem_ff_q, mem_ff_d;
  logic [1:0]                 ld_rd_q, ld_rd_d;
  logic [tbcs_pkg::AddrW-1:0] ld_addr_q, ld_addr_d;

  logic                       res_valid_q, res_valid_d;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_char_q, out_char_d;
  logic [7:0]                 pc_now_q;
  logic [7:0]                 result_byte_q;
  logic [1:0]                 status_q, status_d;

  logic                       slot_free, accept, ld_done, emit;
  tbcs_pkg::mem_wr_t          mem_wr;
  tbcs_pkg::exec_t            ex;
  logic [tbcs_pkg::DataW-1:0] ins, rd_data;
  logic [tbcs_pkg::AddrW-1:0] rd_addr;

  assign slot_free  = !res_valid_q || res_ready_i;
  assign in_ready_o = (state_q == S_RUN) && slot_free;
  assign accept     = in_valid_i && in_ready_o;
  assign ld_done    = (state_q == S_LDW) && slot_free;
  assign rd_addr    = (state_q == S_LDW) ? ld_addr_q : ex.ld_addr;

  tbcs_mem u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (mem_wr),
    .fetch_addr_i(pc_d),
    .fetch_data_o(ins),
    .rd_addr_i   (rd_addr),
    .rd_data_o   (rd_data)
  );

  tbcs_exec u_exec (
    .ins_i    (ins),
    .pc_i     (pc_q),
    .regs_i   (regs_q),
    .in_char_i(in_char_i),
    .ex_o     (ex)
  );

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    regs_d      = regs_q;
    stopped_d   = stopped_q;
    ld_rd_d     = ld_rd_q;
    ld_addr_d   = ld_addr_q;
    mem_wr      = '0;
    emit        = 1'b0;
    out_valid_d = 1'b0;
    out_char_d  = '0;
    status_d    = tbcs_pkg::ST_OK;

    if (accept) begin
      if (action_i == tbcs_pkg::ACT_LOAD) begin
        mem_wr.we   = 1'b1;
        mem_wr.addr = load_addr_i;
        mem_wr.data = load_data_i;
        status_d    = stopped_q ? tbcs_pkg::ST_IGNORED : tbcs_pkg::ST_OK;
        emit        = 1'b1;
      end else if (stopped_q) begin
        status_d = tbcs_pkg::ST_IGNORED;
        emit     = 1'b1;
      end else if (ex.unknown) begin
        stopped_d = 1'b1;
        status_d  = tbcs_pkg::ST_UNKNOWN;
        emit      = 1'b1;
      end else if (ex.is_load) begin
        state_d   = S_LDW;
        ld_rd_d   = ex.reg_idx;
        ld_addr_d = ex.ld_addr;
      end else begin
        if (ex.reg_we) begin
          regs_d[ex.reg_idx] = ex.reg_val;
        end
        mem_wr      = ex.mem_wr;
        pc_d        = ex.pc_next;
        out_valid_d = ex.out_valid;
        out_char_d  = ex.out_char;
        if (ex.pc_next == '0) begin
          stopped_d = 1'b1;
          status_d  = tbcs_pkg::ST_WRAP;
        end
        emit = 1'b1;
      end
    end else if (ld_done) begin
      regs_d[ld_rd_q] = rd_data;
      pc_d            = pc_q + 8'd1;
      if (pc_d == '0) begin
        stopped_d = 1'b1;
        status_d  = tbcs_pkg::ST_WRAP;
      end
      state_d = S_RUN;
      emit    = 1'b1;
    end

    mem_ff_d = mem_ff_q;
    if (mem_wr.we && (mem_wr.addr == tbcs_pkg::RESULT_ADDR)) begin
      mem_ff_d = mem_wr.data;
    end

    res_valid_d = emit || (res_valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_RUN;
      pc_q          <= '0;
      regs_q        <= '0;
      stopped_q     <= 1'b0;
      mem_ff_q      <= '0;
      res_valid_q   <= 1'b0;
      ld_rd_q       <= '0;
      ld_addr_q     <= '0;
      out_valid_q   <= 1'b0;
      out_char_q    <= '0;
      pc_now_q      <= '0;
      result_byte_q <= '0;
      status_q      <= tbcs_pkg::ST_OK;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      regs_q      <= regs_d;
      stopped_q   <= stopped_d;
      mem_ff_q    <= mem_ff_d;
      res_valid_q <= res_valid_d;
      ld_rd_q     <= ld_rd_d;
      ld_addr_q   <= ld_addr_d;
      if (emit) begin
        out_valid_q   <= out_valid_d;
        out_char_q    <= out_char_d;
        pc_now_q      <= pc_d;
        result_byte_q <= mem_ff_d;
        status_q      <= status_d;
      end
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign pc_now_o      = pc_now_q;
  assign result_byte_o = result_byte_q;
  assign status_o      = status_q;

  `TBCS_ASSERT_NEXT(a_stop_sticks, stopped_q, stopped_q, "stop flag cleared without reset")
  `TBCS_ASSERT_NEXT(a_stop_pc_hold, stopped_q, $stable(pc_q), "pc moved while stopped")
  `TBCS_ASSERT_NEXT(a_pc_only_on_emit, !accept && !ld_done, $stable(pc_q),
                    "pc moved without a result")
  `TBCS_ASSERT_NEXT(a_load_completes, (state_q == S_LDW) && slot_free,
                    res_valid_q && (state_q == S_RUN), "load step did not complete")

endmodule
